[design/flow_key_header_parser_unit_defines.svh]
// Assertion macros for the flow key header parser; only the top level includes them.
`ifndef FLOW_KEY_HEADER_PARSER_UNIT_DEFINES_SVH
`define FLOW_KEY_HEADER_PARSER_UNIT_DEFINES_SVH

// Property that must hold at every clock outside reset.
`define FKHP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define FKHP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[design/fkhp_pkg.sv]
// Package: constants, result type and field layout of the flow key header parser.
package fkhp_pkg;

	localparam int MAX_TAGS_DEF = 2;
	localparam int LEN_BITS_DEF = 16;

	// IPv4 header offset never exceeds 14 + 4 * 3 bytes
	localparam int IPS_W = 8;

	localparam logic [15:0] ETH_TPID_Q    = 16'h8100;
	localparam logic [15:0] ETH_TPID_AD   = 16'h88a8;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;

	localparam logic [3:0] IPV4_VERSION = 4'd4;
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
	localparam logic [7:0] IP_PROTO_TCP = 8'd6;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;
	localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

	localparam int TCP_SYN_BIT = 1;
	localparam int TCP_ACK_BIT = 4;

	localparam int OUT_TDATA_W = 128;

	typedef struct packed {
		logic        accepted;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  ip_proto;
		logic        syn_only;
		logic [15:0] frame_length;
	} fkhp_result_t;

endpackage

[design/fkhp_parse.sv]
// Header parse state and per-byte decode of the flow key header parser.
module fkhp_parse #(
	parameter int MAX_TAGS = fkhp_pkg::MAX_TAGS_DEF,
	parameter int LEN_BITS = fkhp_pkg::LEN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             pkt_byte,
	input  logic                   last_byte,
	output fkhp_pkg::fkhp_result_t res
);
	import fkhp_pkg::*;

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	logic [LEN_BITS-1:0] pos_q;
	logic [15:0]         kind_q;
	logic [1:0]          tags_q;
	logic [IPS_W-1:0]    ip_start_q;
	logic [3:0]          ihl_q;
	logic [5:0]          frag_hi_q;
	logic [7:0]          proto_q;
	logic [63:0]         addr_q;
	logic [31:0]         port_q;
	logic [3:0]          doff_q;
	logic                syn_q;
	logic                ack_q;
	logic                rej_q;

	logic [15:0]         kind_n;
	logic [1:0]          tags_n;
	logic [IPS_W-1:0]    ip_start_n;
	logic [3:0]          ihl_n;
	logic [5:0]          frag_hi_n;
	logic [7:0]          proto_n;
	logic [63:0]         addr_n;
	logic [31:0]         port_n;
	logic [3:0]          doff_n;
	logic                syn_n;
	logic                ack_n;
	logic                rej_n;

	logic [15:0]         kind_sh;
	logic [LEN_BITS-1:0] tag_idx;
	logic [LEN_BITS-1:0] rel;
	logic [LEN_BITS-1:0] r4;
	logic [5:0]          l4_bytes;
	logic [LEN_BITS-1:0] count;
	logic [IPS_W-1:0]    need;
	logic                is_tcp;
	logic                ok;

	always_comb begin
		kind_n     = kind_q;
		tags_n     = tags_q;
		ip_start_n = ip_start_q;
		ihl_n      = ihl_q;
		frag_hi_n  = frag_hi_q;
		proto_n    = proto_q;
		addr_n     = addr_q;
		port_n     = port_q;
		doff_n     = doff_q;
		syn_n      = syn_q;
		ack_n      = ack_q;
		rej_n      = rej_q;

		kind_sh  = {kind_q[7:0], pkt_byte};
		tag_idx  = LEN_BITS'(13) + LEN_BITS'({tags_q, 2'b00});
		rel      = pos_q - LEN_BITS'(ip_start_q);
		l4_bytes = {ihl_q, 2'b00};
		r4       = rel - LEN_BITS'(l4_bytes);

		if (!rej_q) begin
			if (ip_start_q == '0) begin
				// still in the Ethernet header or its tags
				kind_n = kind_sh;
				if (pos_q == tag_idx) begin
					if ((kind_sh == ETH_TPID_Q || kind_sh == ETH_TPID_AD) &&
					    32'(tags_q) < MAX_TAGS) begin
						tags_n = tags_q + 2'd1;
					end else if (kind_sh == ETH_TYPE_IPV4) begin
						ip_start_n = pos_q[IPS_W-1:0] + IPS_W'(1);
					end else begin
						rej_n = 1'b1;
					end
				end
			end else if (pos_q >= LEN_BITS'(ip_start_q)) begin
				if (rel == '0) begin
					if (pkt_byte[7:4] != IPV4_VERSION || pkt_byte[3:0] < MIN_HDR_WORDS) begin
						rej_n = 1'b1;
					end else begin
						ihl_n = pkt_byte[3:0];
					end
				end else begin
					if (rel == LEN_BITS'(6)) begin
						frag_hi_n = pkt_byte[5:0];
					end else if (rel == LEN_BITS'(7)) begin
						if ({frag_hi_q, pkt_byte} != '0) begin
							rej_n = 1'b1;
						end
					end else if (rel == LEN_BITS'(9)) begin
						proto_n = pkt_byte;
						if (pkt_byte != IP_PROTO_TCP && pkt_byte != IP_PROTO_UDP) begin
							rej_n = 1'b1;
						end
					end else if (rel >= LEN_BITS'(12) && rel < LEN_BITS'(20)) begin
						addr_n = {addr_q[55:0], pkt_byte};
					end

					// transport header
					if (ihl_q >= MIN_HDR_WORDS && rel >= LEN_BITS'(l4_bytes)) begin
						if (r4 < LEN_BITS'(4)) begin
							port_n = {port_q[23:0], pkt_byte};
						end else if (proto_q == IP_PROTO_TCP && r4 == LEN_BITS'(12)) begin
							doff_n = pkt_byte[7:4];
							if (pkt_byte[7:4] < MIN_HDR_WORDS) begin
								rej_n = 1'b1;
							end
						end else if (proto_q == IP_PROTO_TCP && r4 == LEN_BITS'(13)) begin
							syn_n = pkt_byte[TCP_SYN_BIT];
							ack_n = pkt_byte[TCP_ACK_BIT];
						end
					end
				end
			end
		end

		count  = (pos_q == LEN_MAX) ? pos_q : pos_q + LEN_BITS'(1);
		is_tcp = (proto_n == IP_PROTO_TCP);
		need   = ip_start_n + IPS_W'({ihl_n, 2'b00}) +
		         (is_tcp ? IPS_W'({doff_n, 2'b00}) : UDP_HDR_BYTES);
		ok     = !rej_n && ip_start_n != '0 && ihl_n >= MIN_HDR_WORDS &&
		         (is_tcp ? (doff_n >= MIN_HDR_WORDS) : (proto_n == IP_PROTO_UDP)) &&
		         count >= LEN_BITS'(need);

		res.accepted     = ok;
		res.src_addr     = ok ? addr_n[63:32] : 32'd0;
		res.dst_addr     = ok ? addr_n[31:0] : 32'd0;
		res.sport        = ok ? port_n[31:16] : 16'd0;
		res.dport        = ok ? port_n[15:0] : 16'd0;
		res.ip_proto     = ok ? proto_n : 8'd0;
		res.syn_only     = ok && is_tcp && syn_n && !ack_n;
		res.frame_length = 16'(count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			kind_q     <= '0;
			tags_q     <= '0;
			ip_start_q <= '0;
			ihl_q      <= '0;
			frag_hi_q  <= '0;
			proto_q    <= '0;
			addr_q     <= '0;
			port_q     <= '0;
			doff_q     <= '0;
			syn_q      <= 1'b0;
			ack_q      <= 1'b0;
			rej_q      <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				// frame done: start afresh for the next one
				pos_q      <= '0;
				kind_q     <= '0;
				tags_q     <= '0;
				ip_start_q <= '0;
				ihl_q      <= '0;
				frag_hi_q  <= '0;
				proto_q    <= '0;
				addr_q     <= '0;
				port_q     <= '0;
				doff_q     <= '0;
				syn_q      <= 1'b0;
				ack_q      <= 1'b0;
				rej_q      <= 1'b0;
			end else begin
				pos_q      <= count;
				kind_q     <= kind_n;
				tags_q     <= tags_n;
				ip_start_q <= ip_start_n;
				ihl_q      <= ihl_n;
				frag_hi_q  <= frag_hi_n;
				proto_q    <= proto_n;
				addr_q     <= addr_n;
				port_q     <= port_n;
				doff_q     <= doff_n;
				syn_q      <= syn_n;
				ack_q      <= ack_n;
				rej_q      <= rej_n;
			end
		end
	end

endmodule

[design/flow_key_header_parser_unit.sv]
// Top level of the flow key header parser: input stage, parser and result register.
//
//  channel | dir | beat content                        | accepted when
//  s_*     | in  | one frame byte, tlast on final byte  | s_tvalid && s_tready
//  m_*     | out | one flow key result per frame        | m_tvalid && m_tready
//
// Sustained rate is one byte per clock while the result register is free for each last byte;
// each byte is decoded in a single pass between the input stage register and the result register.
// A frame's result is registered on the cycle its last byte leaves the input
// stage, so it shows on m_* once that byte has passed the input stage and the result register.
// Only a last byte waits on a full result register; other bytes always drain.
// arst_n clears the stage valids and all parse state; payload is not reset.
module flow_key_header_parser_unit #(
	parameter int MAX_TAGS = fkhp_pkg::MAX_TAGS_DEF,
	parameter int LEN_BITS = fkhp_pkg::LEN_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] pkt_byte
	input  logic                             s_tlast,  // last_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] src_addr, [63:32] dst_addr, [79:64] L4 source port,
	// [95:80] L4 destination port, [103:96] ip_proto, [104] syn_only,
	// [120:105] frame_length, [127:121] zero
	output logic [fkhp_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tuser   // [0] accepted
);
	import fkhp_pkg::*;

	`include "flow_key_header_parser_unit_defines.svh"

	localparam int RES_DATA_W = $bits(fkhp_result_t) - 1;

	// input stage
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	// result register
	logic         out_valid_q;
	fkhp_result_t res_q;

	fkhp_result_t res;
	logic         out_free;
	logic         step;

	// A non-last beat never needs the result slot, so it always moves on.
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	fkhp_parse #(
		.MAX_TAGS (MAX_TAGS),
		.LEN_BITS (LEN_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.pkt_byte  (byte_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.accepted;
	assign m_tdata  = {
		(OUT_TDATA_W - RES_DATA_W)'(0),
		res_q.frame_length,
		res_q.syn_only,
		res_q.ip_proto,
		res_q.dport,
		res_q.sport,
		res_q.dst_addr,
		res_q.src_addr
	};

	// rejected frames carry only the length
	`FKHP_ASSERT_IMPL(a_reject_clear, m_tvalid && !m_tuser, m_tdata[104:0] == '0, "rejected result carries key fields")
	// SYN flag only on an accepted TCP key
	`FKHP_ASSERT_IMPL(a_syn_tcp, m_tvalid && m_tdata[104], m_tuser && m_tdata[103:96] == IP_PROTO_TCP, "syn_only without accepted TCP key")
	// a byte that is not the last must never stall in the input stage
	`FKHP_ASSERT_IMPL(a_mid_drain, valid_s1 && !last_s1, s_tready, "mid-frame byte held in input stage")
	// a fresh result only follows a last byte leaving the input stage
	`FKHP_ASSERT_IMPL(a_res_origin, m_tvalid && !$past(m_tvalid), $past(step && last_s1), "result without a last byte")

endmodule
